@@ rtl/eoq_pkg.sv @@
// ----------------------------------------------------------------------------
// eoq_pkg
// Shared types, sizes and helpers of the elevator order queue with LOOK sort.
// ----------------------------------------------------------------------------
package eoq_pkg;

	// table size and floor encoding
	localparam int DEPTH          = 16;
	localparam int FLOOR_BITS     = 4;
	localparam int IDX_W          = $clog2(DEPTH);
	localparam int CNT_W          = $clog2(DEPTH + 1);
	localparam int RANK_W         = FLOOR_BITS + 1;

	// fixed field widths of the item and result transactions
	localparam int OP_W           = 2;
	localparam int FLOOR_FIELD_W  = 4;
	localparam int BUTTON_W       = 2;
	localparam int DIR_FIELD_W    = 2;
	localparam int ORDER_COUNT_W  = 5;

	// queue depths between the parts
	localparam int CQ_DEPTH       = 2;
	localparam int CQ_PTR_W       = $clog2(CQ_DEPTH);
	localparam int CQ_FILL_W      = $clog2(CQ_DEPTH + 1);
	localparam int RQ_DEPTH       = 2;
	localparam int RQ_PTR_W       = $clog2(RQ_DEPTH);
	localparam int RQ_FILL_W      = $clog2(RQ_DEPTH + 1);

	typedef logic [FLOOR_BITS-1:0] floor_t;
	typedef logic [BUTTON_W-1:0]   button_t;
	typedef logic [RANK_W-1:0]     rank_t;

	// operation codes of an item
	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_SORT  = 2'd3
	} op_t;

	// motor direction, code three is folded into stop by the front part
	typedef enum logic [DIR_FIELD_W-1:0] {
		DIR_STOP = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// back part sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DELETE,
		ST_SORT,
		ST_LIST
	} exec_state_t;

	// input transaction
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [FLOOR_FIELD_W-1:0] floor;
		logic [BUTTON_W-1:0]      button;
		logic [FLOOR_FIELD_W-1:0] current_floor;
		logic [DIR_FIELD_W-1:0]   direction;
	} item_t;

	// result transaction
	typedef struct packed {
		logic [FLOOR_FIELD_W-1:0] out_floor;
		logic [BUTTON_W-1:0]      out_button;
		logic                     entry_valid;
		logic                     last;
		logic [ORDER_COUNT_W-1:0] order_count;
		logic                     status;
	} result_t;

	// classified command between front and back
	typedef struct packed {
		op_t     kind;
		floor_t  floor;
		button_t button;
		floor_t  cur;
		dir_t    dir;
	} cmd_t;

	// one table entry
	typedef struct packed {
		floor_t  floor;
		button_t button;
	} entry_t;

	// sort key: upper group ascending, lower group descending, group order by direction
	function automatic rank_t rank_f(floor_t fl, floor_t cur, dir_t dir);
		logic  upper;
		rank_t rank;
		upper = (fl >= cur);
		unique case (dir)
			DIR_UP:   rank = upper ? {1'b0, fl} : {1'b1, ~fl};
			DIR_DOWN: rank = upper ? {1'b1, fl} : {1'b0, ~fl};
			default:  rank = {1'b0, fl};
		endcase
		return rank;
	endfunction

endpackage

@@ rtl/eoq_front.sv @@
// ----------------------------------------------------------------------------
// eoq_front
// Accepts item transactions, decodes them into commands and queues them
// for the back part.
// ----------------------------------------------------------------------------
module eoq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  eoq_pkg::item_t item,
	output logic          cmd_valid,
	input  logic          cmd_pop,
	output eoq_pkg::cmd_t cmd
);
	import eoq_pkg::*;

	cmd_t                 slot_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0]  wr_ptr_q;
	logic [CQ_PTR_W-1:0]  rd_ptr_q;
	logic [CQ_FILL_W-1:0] fill_q;
	cmd_t                 decoded;
	logic                 do_push;
	logic                 do_pop;

	// decode: mask floors to table width, fold unknown direction into stop
	always_comb begin
		decoded.kind   = op_t'(item.op);
		decoded.floor  = FLOOR_BITS'(item.floor);
		decoded.button = item.button;
		decoded.cur    = FLOOR_BITS'(item.current_floor);
		unique case (dir_t'(item.direction))
			DIR_UP:   decoded.dir = DIR_UP;
			DIR_DOWN: decoded.dir = DIR_DOWN;
			default:  decoded.dir = DIR_STOP;
		endcase
	end

	assign full      = (fill_q == CQ_FILL_W'(CQ_DEPTH));
	assign cmd_valid = (fill_q != '0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	// command storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/eoq_exec.sv @@
// ----------------------------------------------------------------------------
// eoq_exec
// Holds the order table and carries out add, delete, clear and sort.
// Delete compacts the table one entry per cycle, sort runs odd-even
// transposition rounds over the filled entries of the table, listing walks it afterwards.
// ----------------------------------------------------------------------------
module eoq_exec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  eoq_pkg::cmd_t    cmd,
	input  logic             res_ready,
	output logic             res_push,
	output eoq_pkg::result_t res_data
);
	import eoq_pkg::*;

	exec_state_t       state_q;
	exec_state_t       state_d;
	entry_t            tab_q [DEPTH];
	entry_t            tab_d [DEPTH];
	entry_t            sorted [DEPTH];
	rank_t             rank [DEPTH];
	logic [DEPTH-1:0]  swap;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic [CNT_W-1:0]  rd_q;
	logic [CNT_W-1:0]  rd_d;
	logic [CNT_W-1:0]  wr_q;
	logic [CNT_W-1:0]  wr_d;
	logic [IDX_W-1:0]  round_q;
	logic [IDX_W-1:0]  round_d;
	floor_t            del_floor_q;
	floor_t            cur_q;
	dir_t              dir_q;
	logic              latch_cmd;
	entry_t            rd_entry;
	entry_t            new_entry;
	logic              list_last;

	assign rd_entry  = tab_q[rd_q[IDX_W-1:0]];
	assign new_entry = '{floor: cmd.floor, button: cmd.button};
	assign list_last = ((rd_q + 1'b1) == count_q);

	// sort keys of all entries
	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			rank[j] = rank_f(tab_q[j].floor, cur_q, dir_q);
		end
	end

	// one transposition round: strict compare keeps equal floors in order
	always_comb begin
		swap = '0;
		for (int j = 0; j < DEPTH - 1; j++) begin
			swap[j] = ((j % 2) == int'(round_q[0])) && (CNT_W'(j + 1) < count_q)
				&& (rank[j] > rank[j+1]);
		end
		for (int j = 0; j < DEPTH; j++) begin
			if (j > 0 && swap[(j > 0) ? j - 1 : 0]) begin
				sorted[j] = tab_q[(j > 0) ? j - 1 : 0];
			end else if (j < DEPTH - 1 && swap[j]) begin
				sorted[j] = tab_q[(j < DEPTH - 1) ? j + 1 : j];
			end else begin
				sorted[j] = tab_q[j];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						OP_DEL:  state_d = ST_DELETE;
						OP_SORT: state_d = (count_q != '0) ? ST_SORT : ST_IDLE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_DELETE: begin
				if (rd_q == count_q && res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_SORT: begin
				if (round_q == IDX_W'(DEPTH - 1)) begin
					state_d = ST_LIST;
				end
			end
			ST_LIST: begin
				if (res_ready && list_last) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// outputs and datapath updates
	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res_data  = '0;
		latch_cmd = 1'b0;
		tab_d     = tab_q;
		count_d   = count_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		round_d   = round_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						OP_ADD: begin
							if (res_ready) begin
								cmd_pop           = 1'b1;
								res_push          = 1'b1;
								res_data.last     = 1'b1;
								if (count_q < CNT_W'(DEPTH)) begin
									tab_d[count_q[IDX_W-1:0]] = new_entry;
									count_d = count_q + 1'b1;
								end else begin
									res_data.status = 1'b1;
								end
								res_data.order_count = ORDER_COUNT_W'(count_d);
							end
						end
						OP_CLEAR: begin
							if (res_ready) begin
								cmd_pop              = 1'b1;
								res_push             = 1'b1;
								res_data.last        = 1'b1;
								count_d              = '0;
								res_data.order_count = '0;
							end
						end
						OP_DEL: begin
							cmd_pop   = 1'b1;
							latch_cmd = 1'b1;
							rd_d      = '0;
							wr_d      = '0;
						end
						OP_SORT: begin
							if (count_q != '0) begin
								cmd_pop   = 1'b1;
								latch_cmd = 1'b1;
								round_d   = '0;
							end else if (res_ready) begin
								cmd_pop       = 1'b1;
								res_push      = 1'b1;
								res_data.last = 1'b1;
							end
						end
					endcase
				end
			end
			ST_DELETE: begin
				if (rd_q != count_q) begin
					if (rd_entry.floor != del_floor_q) begin
						tab_d[wr_q[IDX_W-1:0]] = rd_entry;
						wr_d = wr_q + 1'b1;
					end
					rd_d = rd_q + 1'b1;
				end else if (res_ready) begin
					res_push             = 1'b1;
					res_data.last        = 1'b1;
					res_data.order_count = ORDER_COUNT_W'(wr_q);
					count_d              = wr_q;
				end
			end
			ST_SORT: begin
				tab_d   = sorted;
				round_d = round_q + 1'b1;
				rd_d    = '0;
			end
			ST_LIST: begin
				if (res_ready) begin
					res_push             = 1'b1;
					res_data.out_floor   = FLOOR_FIELD_W'(rd_entry.floor);
					res_data.out_button  = rd_entry.button;
					res_data.entry_valid = 1'b1;
					res_data.last        = list_last;
					res_data.order_count = ORDER_COUNT_W'(count_q);
					rd_d                 = rd_q + 1'b1;
				end
			end
		endcase
	end

	// order table, contents undefined until written
	always_ff @(posedge clk) begin
		tab_q <= tab_d;
	end

	// command operands held while the back part works
	always_ff @(posedge clk) begin
		if (latch_cmd) begin
			del_floor_q <= cmd.floor;
			cur_q       <= cmd.cur;
			dir_q       <= cmd.dir;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_q    <= '0;
			wr_q    <= '0;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_q    <= rd_d;
			wr_q    <= wr_d;
			round_q <= round_d;
		end
	end

endmodule

@@ rtl/eoq_out_queue.sv @@
// ----------------------------------------------------------------------------
// eoq_out_queue
// Result queue between the back part and the result port.
// ----------------------------------------------------------------------------
module eoq_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_push,
	output logic             res_ready,
	input  eoq_pkg::result_t res_data,
	output logic             empty,
	input  logic             pop,
	output eoq_pkg::result_t result
);
	import eoq_pkg::*;

	result_t              slot_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]  wr_ptr_q;
	logic [RQ_PTR_W-1:0]  rd_ptr_q;
	logic [RQ_FILL_W-1:0] fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign res_ready = (fill_q != RQ_FILL_W'(RQ_DEPTH));
	assign empty     = (fill_q == '0);
	assign result    = slot_q[rd_ptr_q];
	assign do_push   = res_push && res_ready;
	assign do_pop    = pop && !empty;

	// result storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= res_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/elevator_order_queue_look_sort.sv @@
// ----------------------------------------------------------------------------
// elevator_order_queue_look_sort
// Elevator order table with add, delete, clear and LOOK-ordered listing.
// ----------------------------------------------------------------------------
// Items enter through a two-deep command queue and results leave through a
// two-deep result queue, so either side may stall without holding the other.
// With an idle back part, an accepted add or clear item is registered in the
// command queue and its result in the result queue that drives the result
// ports. The back part handles one command at a time. Add, clear and a sort
// of an empty table give one result. Delete takes the command, walks the
// count entries of the table and gives its result. Sort takes the command,
// runs DEPTH transposition rounds, then lists the count entries of the table
// one result per cycle while the result queue has room. A full result queue
// holds the back part whenever it has a result to give.
// ----------------------------------------------------------------------------
module elevator_order_queue_look_sort (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  eoq_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output eoq_pkg::result_t result
);
	import eoq_pkg::*;

	cmd_t    cmd;
	logic    cmd_valid;
	logic    cmd_pop;
	logic    res_push;
	logic    res_ready;
	result_t res_data;

	// front: accept and decode
	eoq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// back: table and operations
	eoq_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.res_ready (res_ready),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// result queue
	eoq_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_ready (res_ready),
		.res_data  (res_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
